>>> hw/rtl/lsl_pkg.sv
package lsl_pkg;

    localparam int CFG_W     = 22;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADV_TIMEOUT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IND_ON          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IND_GAP         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IND_PAUSE       = 3'd5;

    // Register values after reset.
    localparam logic [9:0]  RST_SAMPLE_INTERVAL = 10'd50;
    localparam logic [21:0] RST_ADV_TIMEOUT     = 22'd300000;
    localparam logic [15:0] RST_BLINK_HALF      = 16'd500;
    localparam logic [15:0] RST_IND_ON          = 16'd1000;
    localparam logic [15:0] RST_IND_GAP         = 16'd250;
    localparam logic [15:0] RST_IND_PAUSE       = 16'd4000;

    localparam logic [7:0] IDLE_BLUE = 8'd100;
    localparam logic [7:0] LED_FULL  = 8'd255;

    typedef struct packed {
        logic [9:0]  sample_interval_ms;
        logic [21:0] advertise_timeout_ms;
        logic [15:0] adv_blink_half_ms;
        logic [15:0] indicator_on_ms;
        logic [15:0] indicator_gap_ms;
        logic [15:0] indicator_pause_ms;
    } t_cfg;

    typedef struct packed {
        logic       link_button_level;
        logic       reset_button_level;
        logic       peer_connected;
        logic       peer_disconnected;
        logic       limit_write;
        logic [2:0] limit_slot;
        logic [7:0] limit_value;
    } t_in;

    typedef struct packed {
        logic [7:0] red_duty;
        logic [6:0] green_duty;
        logic [7:0] blue_duty;
        logic [1:0] link_mode;
        logic       radio_service;
        logic       drop_link;
        logic       reset_notice;
    } t_out;

endpackage

>>> hw/rtl/lsl_cfg.sv
module lsl_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lsl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lsl_pkg::CFG_W-1:0]          i_cfg_data,
    output lsl_pkg::t_cfg                      o_cfg
);

    lsl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_interval_ms   <= lsl_pkg::RST_SAMPLE_INTERVAL;
            r_cfg.advertise_timeout_ms <= lsl_pkg::RST_ADV_TIMEOUT;
            r_cfg.adv_blink_half_ms    <= lsl_pkg::RST_BLINK_HALF;
            r_cfg.indicator_on_ms      <= lsl_pkg::RST_IND_ON;
            r_cfg.indicator_gap_ms     <= lsl_pkg::RST_IND_GAP;
            r_cfg.indicator_pause_ms   <= lsl_pkg::RST_IND_PAUSE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lsl_pkg::CFG_SAMPLE_INTERVAL: r_cfg.sample_interval_ms <= i_cfg_data[9:0];
                lsl_pkg::CFG_ADV_TIMEOUT:     r_cfg.advertise_timeout_ms <= i_cfg_data;
                lsl_pkg::CFG_BLINK_HALF:      r_cfg.adv_blink_half_ms <= i_cfg_data[15:0];
                lsl_pkg::CFG_IND_ON:          r_cfg.indicator_on_ms <= i_cfg_data[15:0];
                lsl_pkg::CFG_IND_GAP:         r_cfg.indicator_gap_ms <= i_cfg_data[15:0];
                lsl_pkg::CFG_IND_PAUSE:       r_cfg.indicator_pause_ms <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/lsl_step.sv
module lsl_step #(
    parameter int LIMIT_COUNT = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  lsl_pkg::t_in   i_item,
    input  lsl_pkg::t_cfg  i_cfg,
    output lsl_pkg::t_out  o_res
);

    localparam int IDX_W = (LIMIT_COUNT > 1) ? $clog2(LIMIT_COUNT) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_ADV  = 2'd1,
        S_CONN = 2'd2
    } t_link;

    typedef enum logic [1:0] {
        PH_SHOW  = 2'd0,
        PH_GAP   = 2'd1,
        PH_PAUSE = 2'd2
    } t_phase;

    logic [31:0] r_now, n_now;
    logic [31:0] r_sample_stamp, n_sample_stamp;
    logic        r_link_last, n_link_last;
    logic        r_reset_last, n_reset_last;
    t_link       r_link, n_link;
    logic [31:0] r_adv_stamp, n_adv_stamp;
    logic [31:0] r_blink_stamp, n_blink_stamp;
    logic        r_blink_lit, n_blink_lit;
    logic [31:0] r_ind_stamp, n_ind_stamp;
    t_phase      r_ind_phase, n_ind_phase;
    logic [2:0]  r_ind_slot, n_ind_slot;
    logic [7:0]  r_limits [LIMIT_COUNT];
    logic [7:0]  n_limits [LIMIT_COUNT];
    logic [7:0]  r_led_r, n_led_r;
    logic [7:0]  r_led_g, n_led_g;
    logic [7:0]  r_led_b, n_led_b;

    logic [31:0] el_sample, el_adv, el_blink, el_ind;
    logic        link_press, reset_press;
    logic        service, drop, notice;
    logic        wr_ok, show_ok;
    logic [2:0]  slot_next;
    logic [7:0]  show_val;
    t_link       ev_link;

    assign el_sample = r_now - r_sample_stamp;
    assign el_adv    = r_now - r_adv_stamp;
    assign el_blink  = r_now - r_blink_stamp;
    assign el_ind    = r_now - r_ind_stamp;

    assign wr_ok     = i_item.limit_write && ({1'b0, i_item.limit_slot} < 4'(LIMIT_COUNT));
    assign show_ok   = {1'b0, r_ind_slot} < 4'(LIMIT_COUNT);
    assign slot_next = r_ind_slot + 3'd1;

    always_comb begin
        n_now          = r_now + 32'd1;
        n_sample_stamp = r_sample_stamp;
        n_link_last    = r_link_last;
        n_reset_last   = r_reset_last;
        n_adv_stamp    = r_adv_stamp;
        n_blink_stamp  = r_blink_stamp;
        n_blink_lit    = r_blink_lit;
        n_ind_stamp    = r_ind_stamp;
        n_ind_phase    = r_ind_phase;
        n_ind_slot     = r_ind_slot;
        n_limits       = r_limits;
        n_led_r        = r_led_r;
        n_led_g        = r_led_g;
        n_led_b        = r_led_b;
        link_press     = 1'b0;
        reset_press    = 1'b0;
        service        = 1'b0;
        drop           = 1'b0;
        notice         = 1'b0;
        show_val       = 8'd0;

        // Debounce grid: a press is a sampled fall from released to pressed.
        if (el_sample >= 32'(i_cfg.sample_interval_ms)) begin
            n_sample_stamp = r_now;
            n_link_last    = i_item.link_button_level;
            n_reset_last   = i_item.reset_button_level;
            link_press     = r_link_last && !i_item.link_button_level;
            reset_press    = r_reset_last && !i_item.reset_button_level;
        end

        if (wr_ok) begin
            n_limits[i_item.limit_slot[IDX_W-1:0]] = i_item.limit_value;
        end

        ev_link = r_link;
        if (i_item.peer_connected && ev_link == S_ADV) begin
            ev_link = S_CONN;
        end
        if (i_item.peer_disconnected && ev_link == S_CONN) begin
            ev_link = S_IDLE;
        end
        n_link = ev_link;

        unique case (ev_link)
            S_ADV: begin
                if (el_adv >= 32'(i_cfg.advertise_timeout_ms) || link_press) begin
                    n_link = S_IDLE;
                end else begin
                    service = 1'b1;
                    if (el_blink >= 32'(i_cfg.adv_blink_half_ms)) begin
                        n_blink_stamp = r_now;
                        n_led_r       = 8'd0;
                        n_led_g       = 8'd0;
                        n_led_b       = r_blink_lit ? 8'd0 : lsl_pkg::IDLE_BLUE;
                        n_blink_lit   = !r_blink_lit;
                    end
                end
            end
            S_CONN: begin
                service = 1'b1;
                if (link_press) begin
                    drop   = 1'b1;
                    n_link = S_IDLE;
                end else begin
                    if (reset_press) begin
                        notice = 1'b1;
                        for (int i = 0; i < LIMIT_COUNT; i++) begin
                            n_limits[i] = 8'd0;
                        end
                    end
                    show_val = show_ok ? n_limits[r_ind_slot[IDX_W-1:0]] : n_limits[0];
                    if ((r_ind_phase == PH_GAP && el_ind >= 32'(i_cfg.indicator_gap_ms)) ||
                        (r_ind_phase != PH_GAP && r_ind_phase != PH_SHOW &&
                         el_ind >= 32'(i_cfg.indicator_pause_ms))) begin
                        n_ind_stamp = r_now;
                        n_ind_phase = PH_SHOW;
                        n_led_r     = show_val;
                        n_led_g     = lsl_pkg::LED_FULL - show_val;
                        n_led_b     = 8'd0;
                    end else if (r_ind_phase == PH_SHOW &&
                                 el_ind >= 32'(i_cfg.indicator_on_ms)) begin
                        n_ind_stamp = r_now;
                        n_ind_phase = PH_GAP;
                        n_led_r     = 8'd0;
                        n_led_g     = 8'd0;
                        n_led_b     = 8'd0;
                        n_ind_slot  = slot_next;
                        if ({1'b0, slot_next} > 4'(LIMIT_COUNT - 1)) begin
                            n_ind_slot  = 3'd0;
                            n_ind_phase = PH_PAUSE;
                        end
                    end
                end
            end
            default: begin
                n_link  = S_IDLE;
                n_led_r = 8'd0;
                n_led_g = 8'd0;
                n_led_b = lsl_pkg::IDLE_BLUE;
                if (link_press) begin
                    n_link      = S_ADV;
                    n_adv_stamp = r_now;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now          <= 32'd0;
            r_sample_stamp <= 32'd0;
            r_link_last    <= 1'b1;
            r_reset_last   <= 1'b1;
            r_link         <= S_IDLE;
            r_adv_stamp    <= 32'd0;
            r_blink_stamp  <= 32'd0;
            r_blink_lit    <= 1'b0;
            r_ind_stamp    <= 32'd0;
            r_ind_phase    <= PH_SHOW;
            r_ind_slot     <= 3'd0;
            for (int i = 0; i < LIMIT_COUNT; i++) begin
                r_limits[i] <= 8'd0;
            end
            r_led_r        <= 8'd0;
            r_led_g        <= 8'd0;
            r_led_b        <= 8'd0;
        end else if (i_step) begin
            r_now          <= n_now;
            r_sample_stamp <= n_sample_stamp;
            r_link_last    <= n_link_last;
            r_reset_last   <= n_reset_last;
            r_link         <= n_link;
            r_adv_stamp    <= n_adv_stamp;
            r_blink_stamp  <= n_blink_stamp;
            r_blink_lit    <= n_blink_lit;
            r_ind_stamp    <= n_ind_stamp;
            r_ind_phase    <= n_ind_phase;
            r_ind_slot     <= n_ind_slot;
            r_limits       <= n_limits;
            r_led_r        <= n_led_r;
            r_led_g        <= n_led_g;
            r_led_b        <= n_led_b;
        end
    end

    always_comb begin
        o_res.red_duty      = n_led_r;
        o_res.green_duty    = n_led_g[7:1];
        o_res.blue_duty     = n_led_b;
        o_res.link_mode     = n_link;
        o_res.radio_service = service;
        o_res.drop_link     = drop;
        o_res.reset_notice  = notice;
    end

endmodule

>>> hw/rtl/link_status_led_sequencer.sv
// Link status LED sequencer. Each request on the input channel is one millisecond
// tick carrying raw button levels, link events and an optional limit byte write; each
// tick yields exactly one result with the RGB duties and link status. A tick is taken
// into an input register, evaluated combinationally against the controller state,
// and written to an output register, so one tick per clock is sustained when the output
// side is not stalled. Configuration registers are written through the plain write port;
// the user must write them only while no tick is in flight; the block does not enforce it.
module link_status_led_sequencer #(
    parameter int LIMIT_COUNT = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  lsl_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output lsl_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_we,
    input  logic [lsl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsl_pkg::CFG_W-1:0]      i_cfg_data
);

    logic          r_in_valid;
    lsl_pkg::t_in  r_in;
    logic          r_out_valid;
    lsl_pkg::t_out r_out;
    logic          advance;
    logic          in_take;
    lsl_pkg::t_cfg cfg;
    lsl_pkg::t_out res;

    // The held request moves on whenever the output register is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    lsl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lsl_step #(
        .LIMIT_COUNT (LIMIT_COUNT)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
